// File: rtl/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// Shared constants, register codes and state types for the motion pixel
// colour statistics block.
// ----------------------------------------------------------------------------
package mps_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int COORD_BITS_DEF = 11;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 12;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_WIDTH     = 2'd1,
		REG_HEIGHT    = 2'd2
	} cfg_reg_t;

	localparam logic [7:0]  THRESHOLD_RESET = 8'd50;
	localparam logic [11:0] WIDTH_RESET     = 12'd720;
	localparam logic [11:0] HEIGHT_RESET    = 12'd576;

	typedef enum logic [1:0] {
		T_IDLE,
		T_SOLVE,
		T_REPORT
	} top_state_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_MUL_DEN,
		S_MEAN_LD,
		S_DIV_MEAN,
		S_SS_LD,
		S_MUL_SS,
		S_NQ_LD,
		S_MUL_NQ,
		S_SUB,
		S_DIV_VAR,
		S_SQRT,
		S_DONE
	} solve_state_t;

endpackage

// File: rtl/mps_accum.sv
// ----------------------------------------------------------------------------
// mps_accum
// Motion test per pixel, hit counter, channel sums, square sums and the
// bounding box.
// ----------------------------------------------------------------------------
module mps_accum #(
	parameter int COUNT_BITS = mps_pkg::COUNT_BITS_DEF,
	parameter int COORD_BITS = mps_pkg::COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [7:0]              threshold,
	input  logic [7:0]              pix_prev [3],
	input  logic [7:0]              pix_next [3],
	input  logic [COORD_BITS-1:0]   col,
	input  logic [COORD_BITS-1:0]   row,
	input  logic                    take,
	input  logic                    restart,
	input  logic                    load_cols,
	input  logic                    load_rows,
	input  logic [COORD_BITS-1:0]   col_centre,
	input  logic [COORD_BITS-1:0]   row_centre,
	output logic                    hit,
	output logic [COUNT_BITS-1:0]   count,
	output logic [COUNT_BITS+7:0]   sums [3],
	output logic [COUNT_BITS+15:0]  sqsums [3],
	output logic [COORD_BITS-1:0]   left,
	output logic [COORD_BITS-1:0]   right,
	output logic [COORD_BITS-1:0]   upper,
	output logic [COORD_BITS-1:0]   lower
);
	import mps_pkg::*;

	localparam int SW = COUNT_BITS + 8;
	localparam int QW = COUNT_BITS + 16;

	logic [2:0] over;
	logic [7:0] diff [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			diff[c] = (pix_next[c] > pix_prev[c]) ? pix_next[c] - pix_prev[c]
				: pix_prev[c] - pix_next[c];
			over[c] = diff[c] > threshold;
		end
	end

	assign hit = &over;

	logic [COUNT_BITS-1:0]  count_q;
	logic [SW-1:0]          sums_q [3];
	logic [QW-1:0]          sqsums_q [3];
	logic [COORD_BITS-1:0]  left_q, right_q, upper_q, lower_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int c = 0; c < 3; c++) begin
				sums_q[c]   <= '0;
				sqsums_q[c] <= '0;
			end
			left_q  <= COORD_BITS'({{COORD_BITS{1'b0}}, WIDTH_RESET[11:1]});
			right_q <= COORD_BITS'({{COORD_BITS{1'b0}}, WIDTH_RESET[11:1]});
			upper_q <= COORD_BITS'({{COORD_BITS{1'b0}}, HEIGHT_RESET[11:1]});
			lower_q <= COORD_BITS'({{COORD_BITS{1'b0}}, HEIGHT_RESET[11:1]});
		end else begin
			if (restart) begin
				count_q <= '0;
				for (int c = 0; c < 3; c++) begin
					sums_q[c]   <= '0;
					sqsums_q[c] <= '0;
				end
			end else if (take && hit && count_q != '1) begin
				// A full counter freezes the statistics but not the box.
				count_q <= count_q + 1'b1;
				for (int c = 0; c < 3; c++) begin
					sums_q[c]   <= sums_q[c] + SW'(pix_next[c]);
					sqsums_q[c] <= sqsums_q[c] +
						QW'({8'd0, pix_next[c]} * {8'd0, pix_next[c]});
				end
			end
			if (restart || load_cols) begin
				left_q  <= col_centre;
				right_q <= col_centre;
			end else if (take && hit) begin
				if (col < left_q)  left_q  <= col;
				if (col > right_q) right_q <= col;
			end
			if (restart || load_rows) begin
				upper_q <= row_centre;
				lower_q <= row_centre;
			end else if (take && hit) begin
				if (row < upper_q) upper_q <= row;
				if (row > lower_q) lower_q <= row;
			end
		end
	end

	assign count  = count_q;
	assign sums   = sums_q;
	assign sqsums = sqsums_q;
	assign left   = left_q;
	assign right  = right_q;
	assign upper  = upper_q;
	assign lower  = lower_q;

endmodule

// File: rtl/mps_solver.sv
// ----------------------------------------------------------------------------
// mps_solver
// Sequencer around one shared add/subtract unit that works out the mean and
// sample deviation of each channel by shift-add multiplication, restoring
// division and a bit-pair square root.
// ----------------------------------------------------------------------------
module mps_solver #(
	parameter int COUNT_BITS = mps_pkg::COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [COUNT_BITS-1:0]   count,
	input  logic [COUNT_BITS+7:0]   sums [3],
	input  logic [COUNT_BITS+15:0]  sqsums [3],
	output logic                    done,
	output logic [15:0]             mean [3],
	output logic [15:0]             dev [3]
);
	import mps_pkg::*;

	localparam int CB = COUNT_BITS;
	localparam int SW = CB + 8;
	localparam int PW = 2 * CB + 16;
	localparam int NW = PW + 16;
	localparam int DW = 2 * CB;
	localparam int W  = PW + 1;
	localparam int CNT_BITS = $clog2(NW + 1);

	solve_state_t state_q, state_d;

	logic [1:0]           chan_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [PW-1:0]        acc_q, mcand_q, tmp_q;
	logic [SW-1:0]        mplier_q;
	logic [DW-1:0]        den_q, divisor_q, rem_q, quo_q, root_q, rbit_q;
	logic [NW-1:0]        num_q;
	logic [15:0]          mean_q [3];
	logic [15:0]          dev_q [3];

	// Shared unit.
	logic [W-1:0] op_a, op_b, alu;
	logic         op_sub, borrow;
	logic [DW:0]  shifted;
	logic [DW-1:0] quo_next, root_next;
	logic          last, n_ge2;

	assign shifted = {rem_q, num_q[NW-1]};
	assign n_ge2   = |count[CB-1:1];

	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		case (state_q)
			S_DEC: begin
				op_a   = W'(count);
				op_b   = W'(1);
				op_sub = 1'b1;
			end
			S_MUL_DEN, S_MUL_SS, S_MUL_NQ: begin
				op_a = W'(acc_q);
				op_b = W'(mcand_q);
			end
			S_DIV_MEAN, S_DIV_VAR: begin
				op_a   = W'(shifted);
				op_b   = W'(divisor_q);
				op_sub = 1'b1;
			end
			S_SUB: begin
				op_a   = W'(acc_q);
				op_b   = W'(tmp_q);
				op_sub = 1'b1;
			end
			S_SQRT: begin
				op_a   = W'(rem_q);
				op_b   = W'(root_q | rbit_q);
				op_sub = 1'b1;
			end
			default: begin
				op_sub = 1'b0;
			end
		endcase
	end

	assign alu       = op_a + (op_sub ? ~op_b : op_b) + W'(op_sub);
	assign borrow    = alu[W-1];
	assign quo_next  = {quo_q[DW-2:0], ~borrow};
	assign root_next = borrow ? (root_q >> 1) : ((root_q >> 1) | rbit_q);

	always_comb begin
		case (state_q)
			S_MUL_DEN, S_MUL_SS, S_MUL_NQ: last = (cnt_q == CNT_BITS'(SW - 1));
			S_DIV_MEAN, S_DIV_VAR:         last = (cnt_q == CNT_BITS'(NW - 1));
			S_SQRT:                        last = (cnt_q == CNT_BITS'(CB - 1));
			default:                       last = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		case (state_q)
			S_IDLE:    if (start) state_d = S_DEC;
			S_DEC:     state_d = S_MUL_DEN;
			S_MUL_DEN: if (last) state_d = S_MEAN_LD;
			S_MEAN_LD: state_d = S_DIV_MEAN;
			S_DIV_MEAN: begin
				if (last) begin
					if (n_ge2)             state_d = S_SS_LD;
					else if (chan_q == 2'd2) state_d = S_DONE;
					else                    state_d = S_MEAN_LD;
				end
			end
			S_SS_LD:   state_d = S_MUL_SS;
			S_MUL_SS:  if (last) state_d = S_NQ_LD;
			S_NQ_LD:   state_d = S_MUL_NQ;
			S_MUL_NQ:  if (last) state_d = S_SUB;
			S_SUB:     state_d = S_DIV_VAR;
			S_DIV_VAR: if (last) state_d = S_SQRT;
			S_SQRT: begin
				if (last) state_d = (chan_q == 2'd2) ? S_DONE : S_MEAN_LD;
			end
			S_DONE: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chan_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) chan_q <= '0;
			else if (state_d == S_MEAN_LD && state_q != S_MUL_DEN) chan_q <= chan_q + 1'b1;
			cnt_q <= (last || state_d != state_q) ? '0 : cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_DEC: begin
				mplier_q <= SW'(alu);
				mcand_q  <= PW'(count);
				acc_q    <= '0;
			end
			S_MUL_DEN, S_MUL_SS, S_MUL_NQ: begin
				if (mplier_q[0]) acc_q <= alu[PW-1:0];
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			S_MEAN_LD: begin
				if (chan_q == 2'd0) den_q <= acc_q[DW-1:0];
				num_q     <= NW'({sums[chan_q], 8'b0});
				rem_q     <= '0;
				quo_q     <= '0;
				divisor_q <= DW'(count);
			end
			S_DIV_MEAN, S_DIV_VAR: begin
				quo_q <= quo_next;
				num_q <= num_q << 1;
				if (state_q == S_DIV_MEAN && last) begin
					// Division by zero would give all ones; no hits means zero.
					mean_q[chan_q] <= (count == '0) ? 16'd0 : quo_next[15:0];
					if (!n_ge2) dev_q[chan_q] <= 16'd0;
				end
				if (state_q == S_DIV_VAR && last) begin
					rem_q  <= quo_next;
					root_q <= '0;
					rbit_q <= DW'(1) << (DW - 2);
				end else begin
					rem_q <= borrow ? shifted[DW-1:0] : alu[DW-1:0];
				end
			end
			S_SS_LD: begin
				mcand_q  <= PW'(sums[chan_q]);
				mplier_q <= sums[chan_q];
				acc_q    <= '0;
			end
			S_NQ_LD: begin
				tmp_q    <= acc_q;
				mcand_q  <= PW'(sqsums[chan_q]);
				mplier_q <= SW'(count);
				acc_q    <= '0;
			end
			S_SUB: begin
				num_q     <= {alu[PW-1:0], 16'b0};
				rem_q     <= '0;
				quo_q     <= '0;
				divisor_q <= den_q;
			end
			S_SQRT: begin
				if (!borrow) rem_q <= alu[DW-1:0];
				root_q <= root_next;
				rbit_q <= rbit_q >> 2;
				if (last) dev_q[chan_q] <= root_next[15:0];
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign mean = mean_q;
	assign dev  = dev_q;

endmodule

// File: rtl/motion_pixel_colour_statistics.sv
// ----------------------------------------------------------------------------
// motion_pixel_colour_statistics
// Frame difference motion mask with per-channel mean, sample standard
// deviation and bounding box of the motion pixels.
// ----------------------------------------------------------------------------
// Every pixel transfer gives one result transfer. Pixels without last_pixel
// stream at one per clock as long as the result side keeps up; while a
// result is stalled no pixel enters, and the next pixel may enter in the
// same cycle that the waiting result leaves. A pixel with last_pixel set
// starts the statistics sequencer, which runs everything through one shared
// adder. Its division steps, one quotient bit per cycle, dominate its run,
// and it runs fewer steps when under two motion pixels were seen. While the
// sequencer runs, in_ready is low; configuration writes should only be made
// while idle.
module motion_pixel_colour_statistics #(
	parameter int COUNT_BITS = mps_pkg::COUNT_BITS_DEF,
	parameter int COORD_BITS = mps_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [mps_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           prev_red,
	input  logic [7:0]                           prev_green,
	input  logic [7:0]                           prev_blue,
	input  logic [7:0]                           next_red,
	input  logic [7:0]                           next_green,
	input  logic [7:0]                           next_blue,
	input  logic [10:0]                          column,
	input  logic [10:0]                          row,
	input  logic                                 last_pixel,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 motion_hit,
	output logic                                 stats_valid,
	output logic [15:0]                          mean_red,
	output logic [15:0]                          mean_green,
	output logic [15:0]                          mean_blue,
	output logic [15:0]                          dev_red,
	output logic [15:0]                          dev_green,
	output logic [15:0]                          dev_blue,
	output logic [10:0]                          box_left,
	output logic [10:0]                          box_right,
	output logic [10:0]                          box_top,
	output logic [10:0]                          box_bottom
);
	import mps_pkg::*;

	// Configuration registers. A width or height write also reloads the
	// matching box bounds with the new centre in the same cycle.
	logic [7:0]  thr_q;
	logic [11:0] width_q, height_q;
	logic        wr_width, wr_height;

	assign wr_width  = cfg_we && (cfg_index == REG_WIDTH);
	assign wr_height = cfg_we && (cfg_index == REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THRESHOLD_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q    <= cfg_data[7:0];
				REG_WIDTH:     width_q  <= cfg_data;
				REG_HEIGHT:    height_q <= cfg_data;
				default:       thr_q    <= thr_q;
			endcase
		end
	end

	// The centre is half the frame size, masked to the coordinate width.
	logic [11:0]           width_src, height_src;
	logic [COORD_BITS-1:0] col_centre, row_centre;

	assign width_src  = wr_width  ? cfg_data : width_q;
	assign height_src = wr_height ? cfg_data : height_q;
	assign col_centre = COORD_BITS'({{COORD_BITS{1'b0}}, width_src[11:1]});
	assign row_centre = COORD_BITS'({{COORD_BITS{1'b0}}, height_src[11:1]});

	// Control: idle pixels flow straight through; a last pixel hands over to
	// the sequencer, then the statistics wait for a free result register.
	top_state_t state_q, state_d;
	logic slot_free, accept, restart, start_q, last_hit_q, solve_done;
	logic out_valid_q;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		restart  = 1'b0;
		case (state_q)
			T_IDLE: begin
				in_ready = slot_free;
				if (in_valid && slot_free && last_pixel) state_d = T_SOLVE;
			end
			T_SOLVE: begin
				if (solve_done) state_d = T_REPORT;
			end
			T_REPORT: begin
				if (slot_free) begin
					restart = 1'b1;
					state_d = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= accept && last_pixel;
		end
	end

	// Datapath: motion test and accumulation.
	logic [7:0]             pix_prev [3];
	logic [7:0]             pix_next [3];
	logic                   hit;
	logic [COUNT_BITS-1:0]  count;
	logic [COUNT_BITS+7:0]  sums [3];
	logic [COUNT_BITS+15:0] sqsums [3];
	logic [COORD_BITS-1:0]  b_left, b_right, b_upper, b_lower;
	logic [15:0]            mean [3];
	logic [15:0]            dev [3];

	assign pix_prev[0] = prev_red;
	assign pix_prev[1] = prev_green;
	assign pix_prev[2] = prev_blue;
	assign pix_next[0] = next_red;
	assign pix_next[1] = next_green;
	assign pix_next[2] = next_blue;

	mps_accum #(
		.COUNT_BITS (COUNT_BITS),
		.COORD_BITS (COORD_BITS)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.threshold  (thr_q),
		.pix_prev   (pix_prev),
		.pix_next   (pix_next),
		.col        (COORD_BITS'({{COORD_BITS{1'b0}}, column})),
		.row        (COORD_BITS'({{COORD_BITS{1'b0}}, row})),
		.take       (accept),
		.restart    (restart),
		.load_cols  (wr_width),
		.load_rows  (wr_height),
		.col_centre (col_centre),
		.row_centre (row_centre),
		.hit        (hit),
		.count      (count),
		.sums       (sums),
		.sqsums     (sqsums),
		.left       (b_left),
		.right      (b_right),
		.upper      (b_upper),
		.lower      (b_lower)
	);

	// The sequencer starts in the cycle after the last pixel is taken, so that
	// it sees the sums with that pixel already folded in.
	mps_solver #(
		.COUNT_BITS (COUNT_BITS)
	) u_solver (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.count  (count),
		.sums   (sums),
		.sqsums (sqsums),
		.done   (solve_done),
		.mean   (mean),
		.dev    (dev)
	);

	always_ff @(posedge clk) begin
		if (accept) last_hit_q <= hit;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && !last_pixel) || restart) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !last_pixel) begin
			motion_hit  <= hit;
			stats_valid <= 1'b0;
			mean_red    <= '0;
			mean_green  <= '0;
			mean_blue   <= '0;
			dev_red     <= '0;
			dev_green   <= '0;
			dev_blue    <= '0;
			box_left    <= '0;
			box_right   <= '0;
			box_top     <= '0;
			box_bottom  <= '0;
		end else if (restart) begin
			motion_hit  <= last_hit_q;
			stats_valid <= 1'b1;
			mean_red    <= mean[0];
			mean_green  <= mean[1];
			mean_blue   <= mean[2];
			dev_red     <= dev[0];
			dev_green   <= dev[1];
			dev_blue    <= dev[2];
			box_left    <= 11'({{11{1'b0}}, b_left});
			box_right   <= 11'({{11{1'b0}}, b_right});
			box_top     <= 11'({{11{1'b0}}, b_upper});
			box_bottom  <= 11'({{11{1'b0}}, b_lower});
		end
	end

	assign out_valid = out_valid_q;

	// No pixel may enter while statistics are being worked out or reported.
	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != T_IDLE) |-> !in_ready)
		else $error("pixel accepted while statistics pending");

	// The sequencer only finishes while the control side is waiting for it.
	a_done_in_solve: assert property (@(posedge clk) disable iff (!arst_n)
		solve_done |-> (state_q == T_SOLVE))
		else $error("sequencer finished outside solve phase");

	// Leaving the report phase always presents a statistics result.
	a_report_shows_stats: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> (out_valid && stats_valid))
		else $error("statistics result not presented");

endmodule
